// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ipcpwm_pkg.sv =====
// Package for the inverse Park/Clarke PWM duty block: payload types,
// fixed-point constants and parameter defaults. No dependencies.
package ipcpwm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF  = 16;

  localparam logic [15:0] SUPPLY_RESET = 16'd49152;

  // quarter-turn sine polynomial coefficients, Q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569310;
  localparam logic [30:0] SIN_C7 = 31'd5026996;
  localparam logic [30:0] SIN_C9 = 31'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

  localparam int SINE_LAT = 7;

  typedef struct packed {
    logic signed [16:0] uq_command;
    logic signed [31:0] elec_angle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic        command_limited;
  } duty_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic lim;
  } div_ctl_t;

endpackage

// ===== rtl/ipcpwm_sine.sv =====
// Pipelined sine of a binary angle, Q30 signed result.
// Odd polynomial per quarter turn, one multiply per stage. Uses ipcpwm_pkg.
module ipcpwm_sine import ipcpwm_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-1:0]   angle,
  output logic signed [31:0]      sine
);

  localparam int FB = ANGLE_BITS - 2;

  logic [30:0] x   [0:5];
  logic        neg [0:5];
  logic [30:0] x2  [1:4];
  logic [30:0] t   [2:5];
  logic [30:0] x_in;
  logic [30:0] x_raw;
  logic [61:0] p_sq, p2, p3, p4, p5, p6;
  logic [30:0] s_mag;

  always_comb begin
    x_raw = 31'(angle[FB-1:0]) << (30 - FB);
    x_in  = angle[FB] ? (ONE_Q30 - x_raw) : x_raw;
    p_sq  = 62'(x[0]) * 62'(x[0]);
    p2    = 62'(x2[1]) * 62'(SIN_C9);
    p3    = 62'(x2[2]) * 62'(t[2]);
    p4    = 62'(x2[3]) * 62'(t[3]);
    p5    = 62'(x2[4]) * 62'(t[4]);
    p6    = 62'(x[5]) * 62'(t[5]);
    s_mag = (p6[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : p6[60:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= x_in;
      neg[0] <= angle[ANGLE_BITS-1];
      for (int i = 1; i < 6; i++) begin
        x[i]   <= x[i-1];
        neg[i] <= neg[i-1];
      end
      x2[1] <= p_sq[60:30];
      for (int i = 2; i < 5; i++) x2[i] <= x2[i-1];
      t[2] <= 31'(SIN_C7 - p2[60:30]);
      t[3] <= 31'(SIN_C5 - p3[60:30]);
      t[4] <= 31'(SIN_C3 - p4[60:30]);
      t[5] <= 31'(SIN_C1 - p5[60:30]);
      sine <= neg[5] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    end
  end

endmodule

// ===== rtl/ipcpwm_div_cell.sv =====
// One restoring-division step for the three phase lanes.
// Cells are chained, one quotient bit per cell. Uses ipcpwm_pkg.
module ipcpwm_div_cell import ipcpwm_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [30:0]               dvsr,
  input  div_ctl_t                  ctl_in,
  input  logic [2:0][30:0]          rem_in,
  input  logic [2:0][DUTY_BITS-1:0] nq_in,
  output div_ctl_t                  ctl_out,
  output logic [2:0][30:0]          rem_out,
  output logic [2:0][DUTY_BITS-1:0] nq_out
);

  logic [2:0][31:0]          trial;
  logic [2:0]                ge;
  logic [2:0][30:0]          rem_next;
  logic [2:0][DUTY_BITS-1:0] nq_next;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trial[l]    = {rem_in[l], nq_in[l][DUTY_BITS-1]};
      ge[l]       = trial[l] >= {1'b0, dvsr};
      rem_next[l] = ge[l] ? 31'(trial[l] - {1'b0, dvsr}) : trial[l][30:0];
      nq_next[l]  = {nq_in[l][DUTY_BITS-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.zero <= ctl_in.zero;
      ctl_out.lim  <= ctl_in.lim;
      rem_out      <= rem_next;
      nq_out       <= nq_next;
    end
  end

endmodule

// ===== rtl/inverse_park_clarke_pwm_duty_top.sv =====
// Top level: command clamp, sine pipelines, inverse Park/Clarke, divider chain.
// Uses ipcpwm_pkg, ipcpwm_sine, ipcpwm_div_cell, assert_macros.svh.
//
//  channel | signals                          | payload
//  cmd     | cmd_valid, cmd_stall             | cmd_t (uq_command, elec_angle)
//  duty    | duty_valid, duty_stall           | duty_t (three duties, limit flag)
//  cfg     | cfg_valid, cfg_ready             | supply_voltage, 16 bit
//
// One item per cycle unless the output stalls; the transfer
// edge loads the first of seven sine stages, then six arithmetic stages, one divider
// cell per duty bit and the output register.
// Synchronous reset clears the valid bits and loads supply_voltage to 12.0 V.
// A stalled result freezes the whole pipeline; cfg is always ready.
`include "assert_macros.svh"
module inverse_park_clarke_pwm_duty_top import ipcpwm_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int DUTY_BITS  = DUTY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd_data,
  output logic        duty_valid,
  input  logic        duty_stall,
  output duty_t       duty_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PRE = SINE_LAT + 6;
  localparam int NW  = 31 + DUTY_BITS;
  localparam logic [DUTY_BITS-1:0] DMAX = '1;

  logic [15:0] supply;
  logic        adv;
  logic [PRE-1:0] pv;

  // front end
  logic signed [17:0] u_raw, half_s, u_clamp;
  logic               lim_c;
  logic [ANGLE_BITS-1:0] ang, angc;
  logic signed [17:0] u_d   [0:SINE_LAT-1];
  logic               lim_d [0:SINE_LAT+5];
  logic signed [31:0] sn, cs;

  logic signed [49:0] pa, pb;
  logic signed [49:0] pa_neg;
  logic signed [33:0] alpha2, beta2, alpha3, alpha4;
  logic signed [65:0] s3p;
  logic signed [35:0] s3b;
  logic signed [37:0] half27, va, vb, vc, dif_b, dif_c;
  logic [30:0]        sup27;
  logic [2:0][37:0]   v4;
  logic [2:0][NW-1:0] num;
  logic [2:0][30:0]   vcl;
  logic [2:0][NW:0]   num_next;

  assign cfg_ready = 1'b1;
  assign adv       = !(duty_valid && duty_stall);
  assign cmd_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= SUPPLY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      supply <= cfg_data;
    end
  end

  always_comb begin
    u_raw  = {cmd_data.uq_command, 1'b0};
    half_s = $signed({2'b00, supply});
    lim_c  = 1'b0;
    u_clamp = u_raw;
    if (u_raw > half_s) begin
      u_clamp = half_s;
      lim_c   = 1'b1;
    end else if (u_raw < -half_s) begin
      u_clamp = -half_s;
      lim_c   = 1'b1;
    end
    ang  = cmd_data.elec_angle[ANGLE_BITS-1:0];
    angc = ang + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
  end

  ipcpwm_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
    .clk(clk), .en(adv), .angle(ang), .sine(sn)
  );
  ipcpwm_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
    .clk(clk), .en(adv), .angle(angc), .sine(cs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (adv) begin
      pv <= {pv[PRE-2:0], cmd_valid};
    end
  end

  always_comb begin
    pa_neg = -pa;
    half27 = 38'({supply, 14'd0});
    sup27  = {supply, 15'd0};
    dif_b  = 38'(s3b) - 38'(alpha4);
    dif_c  = -38'(alpha4) - 38'(s3b);
    va     = 38'(alpha4) + half27;
    vb     = (dif_b >>> 1) + half27;
    vc     = (dif_c >>> 1) + half27;
    for (int l = 0; l < 3; l++) begin
      if (v4[l][37]) begin
        vcl[l] = '0;
      end else if (v4[l] > 38'(sup27)) begin
        vcl[l] = sup27;
      end else begin
        vcl[l] = v4[l][30:0];
      end
      // v * (2^DUTY_BITS - 1) + supply27 / 2
      num_next[l] = ((NW+1)'(vcl[l]) << DUTY_BITS) - (NW+1)'(vcl[l])
                    + (NW+1)'({supply, 14'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_d[0]   <= u_clamp;
      lim_d[0] <= lim_c;
      for (int i = 1; i < SINE_LAT; i++) u_d[i] <= u_d[i-1];
      for (int i = 1; i < SINE_LAT + 6; i++) lim_d[i] <= lim_d[i-1];
      pa     <= 50'(u_d[SINE_LAT-1]) * 50'(sn);
      pb     <= 50'(u_d[SINE_LAT-1]) * 50'(cs);
      alpha2 <= 34'(pa_neg >>> 16);
      beta2  <= 34'(pb >>> 16);
      alpha3 <= alpha2;
      alpha4 <= alpha3;
      s3p    <= 66'(beta2) * 66'(SQRT3_Q30);
      s3b    <= 36'(s3p >>> 30);
      v4[0]  <= va;
      v4[1]  <= vb;
      v4[2]  <= vc;
      for (int l = 0; l < 3; l++) num[l] <= num_next[l][NW-1:0];
    end
  end

  // divider chain
  div_ctl_t                  ctl_c [0:DUTY_BITS];
  logic [2:0][30:0]          rem_c [0:DUTY_BITS];
  logic [2:0][DUTY_BITS-1:0] nq_c  [0:DUTY_BITS];

  always_comb begin
    ctl_c[0].valid = pv[PRE-1];
    ctl_c[0].zero  = (supply == 16'd0);
    ctl_c[0].lim   = lim_d[SINE_LAT+5];
    for (int l = 0; l < 3; l++) begin
      rem_c[0][l] = num[l][NW-1:DUTY_BITS];
      nq_c[0][l]  = num[l][DUTY_BITS-1:0];
    end
  end

  for (genvar g = 0; g < DUTY_BITS; g++) begin : g_div
    ipcpwm_div_cell #(.DUTY_BITS(DUTY_BITS)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .dvsr(sup27),
      .ctl_in(ctl_c[g]), .rem_in(rem_c[g]), .nq_in(nq_c[g]),
      .ctl_out(ctl_c[g+1]), .rem_out(rem_c[g+1]), .nq_out(nq_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_valid <= 1'b0;
    end else if (adv) begin
      duty_valid <= ctl_c[DUTY_BITS].valid;
    end
    if (adv) begin
      duty_data.duty_a <= ctl_c[DUTY_BITS].zero ? 16'd0 : 16'(nq_c[DUTY_BITS][0]);
      duty_data.duty_b <= ctl_c[DUTY_BITS].zero ? 16'd0 : 16'(nq_c[DUTY_BITS][1]);
      duty_data.duty_c <= ctl_c[DUTY_BITS].zero ? 16'd0 : 16'(nq_c[DUTY_BITS][2]);
      duty_data.command_limited <= ctl_c[DUTY_BITS].lim;
    end
  end

  `ASSERT_IMPLIES(a_duty_range, clk, rst, duty_valid,
    (duty_data.duty_a <= 16'(DMAX)) && (duty_data.duty_b <= 16'(DMAX)) && (duty_data.duty_c <= 16'(DMAX)))
  `ASSERT_IMPLIES(a_zero_supply, clk, rst, duty_valid && (supply == 16'd0),
    (duty_data.duty_a == 16'd0) && (duty_data.duty_b == 16'd0) && (duty_data.duty_c == 16'd0))
  `ASSERT_NEXT(a_chain_out, clk, rst, adv && ctl_c[DUTY_BITS].valid, duty_valid)

endmodule
